FILE: hdl/tsgd_pkg.sv
package tsgd_pkg;

    localparam int unsigned NUM_PADS = 8;
    localparam int unsigned PAD_IDX_W = 3;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned CODE_W = 4;

    localparam logic [TIMER_W-1:0] FIRST_WINDOW_RESET = 16'd3000;
    localparam logic [TIMER_W-1:0] REARM_DELAY_RESET = 16'd400;

    localparam logic [CODE_W-1:0] NO_CODE = 4'd0;
    localparam logic [CODE_W-1:0] MAX_CODE = 4'd12;

    localparam logic REG_FIRST_WINDOW = 1'b0;
    localparam logic REG_REARM_DELAY = 1'b1;

    typedef struct packed {
        logic [TIMER_W-1:0] first_window;
        logic [TIMER_W-1:0] rearm_delay;
    } tsgd_cfg_t;

    // Rows are the first pad, columns the second pad.
    localparam logic [CODE_W-1:0] SWIPE_TABLE [0:NUM_PADS-1][0:NUM_PADS-1] = '{
        '{4'd0, 4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd4, 4'd0},
        '{4'd0, 4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0, 4'd9},
        '{4'd0, 4'd0,  4'd0, 4'd5,  4'd0,  4'd8, 4'd0, 4'd0},
        '{4'd0, 4'd0,  4'd6, 4'd0,  4'd12, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0,  4'd0, 4'd11, 4'd0,  4'd2, 4'd0, 4'd0},
        '{4'd0, 4'd0,  4'd7, 4'd0,  4'd1,  4'd0, 4'd0, 4'd0},
        '{4'd3, 4'd0,  4'd0, 4'd0,  4'd0,  4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd10, 4'd0, 4'd0,  4'd0,  4'd0, 4'd0, 4'd0}
    };

endpackage

FILE: hdl/tsgd_cfg_regs.sv
module tsgd_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output tsgd_pkg::tsgd_cfg_t cfg
);
    import tsgd_pkg::*;

    logic [TIMER_W-1:0] first_window_reg;
    logic [TIMER_W-1:0] rearm_delay_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_window_reg <= FIRST_WINDOW_RESET;
            rearm_delay_reg <= REARM_DELAY_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FIRST_WINDOW: first_window_reg <= pwdata[TIMER_W-1:0];
                REG_REARM_DELAY:  rearm_delay_reg <= pwdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FIRST_WINDOW: prdata = {{(32-TIMER_W){1'b0}}, first_window_reg};
            REG_REARM_DELAY:  prdata = {{(32-TIMER_W){1'b0}}, rearm_delay_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.first_window = first_window_reg;
    assign cfg.rearm_delay = rearm_delay_reg;

endmodule

FILE: hdl/tsgd_scan_core.sv
module tsgd_scan_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        scan_fire,
    input  logic [tsgd_pkg::NUM_PADS-1:0] pad_levels,
    input  tsgd_pkg::tsgd_cfg_t         cfg,
    output logic [tsgd_pkg::CODE_W-1:0] gesture_code,
    output logic                        code_written
);
    import tsgd_pkg::*;

    logic [PAD_IDX_W-1:0] first_pad_reg, first_pad_next;
    logic                 first_armed_reg, first_armed_next;
    logic                 second_taken_reg, second_taken_next;
    logic [TIMER_W-1:0]   window_timer_reg, window_timer_next;
    logic [TIMER_W-1:0]   rearm_timer_reg, rearm_timer_next;
    logic [CODE_W-1:0]    held_code_reg, held_code_next;
    logic                 wrote;

    always_comb begin
        logic [PAD_IDX_W-1:0] fp;
        logic                 fa;
        logic                 st;
        logic [TIMER_W-1:0]   wt;
        logic [TIMER_W-1:0]   rt;
        logic [CODE_W-1:0]    hc;
        logic [CODE_W-1:0]    code;
        logic [TIMER_W:0]     wt_inc;
        logic [TIMER_W:0]     rt_inc;
        fp = first_pad_reg;
        fa = first_armed_reg;
        st = second_taken_reg;
        wt = window_timer_reg;
        rt = rearm_timer_reg;
        hc = held_code_reg;
        wrote = 1'b0;
        code = NO_CODE;
        // Each pad sees the marks and timers as left by the pads before it.
        for (int p = 0; p < NUM_PADS; p++) begin
            if (pad_levels[p]) begin
                if (!fa && (rt >= cfg.rearm_delay)) begin
                    fp = PAD_IDX_W'(p);
                    fa = 1'b1;
                    wt = '0;
                end else if ((PAD_IDX_W'(p) != fp) && !st && (wt < cfg.first_window)) begin
                    code = SWIPE_TABLE[fp][PAD_IDX_W'(p)];
                    st = 1'b1;
                    if (code != NO_CODE) begin
                        hc = code;
                        wrote = 1'b1;
                    end else begin
                        fa = 1'b0;
                        st = 1'b0;
                    end
                end else begin
                    rt = '0;
                end
            end
        end
        wt_inc = {1'b0, wt} + 1'b1;
        if (wt_inc > {1'b0, cfg.first_window}) begin
            fa = 1'b0;
        end else begin
            wt = wt_inc[TIMER_W-1:0];
        end
        rt_inc = {1'b0, rt} + 1'b1;
        if (rt_inc > {1'b0, cfg.rearm_delay}) begin
            st = 1'b0;
        end else begin
            rt = rt_inc[TIMER_W-1:0];
        end
        first_pad_next = fp;
        first_armed_next = fa;
        second_taken_next = st;
        window_timer_next = wt;
        rearm_timer_next = rt;
        held_code_next = hc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pad_reg <= '0;
            first_armed_reg <= 1'b0;
            second_taken_reg <= 1'b0;
            window_timer_reg <= '0;
            rearm_timer_reg <= REARM_DELAY_RESET;
            held_code_reg <= NO_CODE;
        end else if (scan_fire) begin
            first_pad_reg <= first_pad_next;
            first_armed_reg <= first_armed_next;
            second_taken_reg <= second_taken_next;
            window_timer_reg <= window_timer_next;
            rearm_timer_reg <= rearm_timer_next;
            held_code_reg <= held_code_next;
        end
    end

    assign gesture_code = held_code_next;
    assign code_written = wrote;

    assert property (@(posedge aclk) disable iff (!aresetn)
        held_code_reg <= MAX_CODE)
        else $error("held gesture code out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_fire && wrote) |=> (held_code_reg != NO_CODE))
        else $error("a written gesture code is zero");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !scan_fire |=> ($stable(held_code_reg) && $stable(first_armed_reg)
                        && $stable(window_timer_reg) && $stable(rearm_timer_reg)))
        else $error("gesture state changed without a scan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_fire && !wrote) |=> $stable(held_code_reg))
        else $error("held code changed on a scan that wrote no code");

endmodule

FILE: hdl/touch_swipe_gesture_detector_unit.sv
// Path: a result passes through the input register and then the result register.
// Throughput: one scan per cycle while m_tready does not stall the output; the eight-pad chain and
// both timer updates run combinationally between the input register and the result register.
// Reset: aresetn is synchronous and active low; it clears all marks, the window timer and the held code,
// loads the rearm timer with 400 and the registers with their defaults, and empties both stages.
module touch_swipe_gesture_detector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pad_levels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] gesture_code, [7:4] zero
    output logic [0:0]  m_tuser,   // [0] code_written
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tsgd_pkg::*;

    tsgd_cfg_t           cfg;
    logic                in_valid_reg;
    logic [NUM_PADS-1:0] in_pads_reg;
    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic                out_written_reg;
    logic                scan_fire;
    logic [CODE_W-1:0]   res_code;
    logic                res_written;

    tsgd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign scan_fire = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | scan_fire;

    tsgd_scan_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .scan_fire    (scan_fire),
        .pad_levels   (in_pads_reg),
        .cfg          (cfg),
        .gesture_code (res_code),
        .code_written (res_written)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (scan_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pads_reg <= s_tdata;
        end
        if (scan_fire) begin
            out_code_reg <= res_code;
            out_written_reg <= res_written;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(8-CODE_W){1'b0}}, out_code_reg};
    assign m_tuser = out_written_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full and stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        scan_fire |=> m_tvalid)
        else $error("processed scan produced no result");

endmodule
